// File: design/elgamal_signature_engine_top_assert.svh
// Assertion macros used by the engine top level.
`ifndef ELGAMAL_SIGNATURE_ENGINE_TOP_ASSERT_SVH
`define ELGAMAL_SIGNATURE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication.
`define EGS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define EGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/egs_pkg.sv
// ----------------------------------------------------------------------------
// egs_pkg
// Shared widths, codes and unit request types of the ElGamal signature engine.
// ----------------------------------------------------------------------------
package egs_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  localparam logic [1:0] OP_KEYGEN = 2'd0;
  localparam logic [1:0] OP_SIGN   = 2'd1;
  localparam logic [1:0] OP_VERIFY = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] REG_PRIME = 2'd0;
  localparam logic [1:0] REG_GEN   = 2'd1;
  localparam logic [1:0] REG_KEY   = 2'd2;

  localparam logic [WIDTH-1:0] PRIME_RST = WIDTH'(19);
  localparam logic [WIDTH-1:0] GEN_RST   = WIDTH'(10);
  localparam logic [WIDTH-1:0] KEY_RST   = WIDTH'(16);

  // Modular product a*b mod m, a < m, b any value.
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] m;
  } mul_req_t;

  // Quotient and remainder num / den, den nonzero.
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] num;
    logic [WIDTH-1:0] den;
  } div_req_t;

endpackage

// File: design/egs_modmul.sv
// ----------------------------------------------------------------------------
// egs_modmul
// Bit-serial modular multiplier: one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
module egs_modmul (
  input  logic                     clk,
  input  logic                     rst,
  input  egs_pkg::mul_req_t        req,
  output logic                     done,
  output logic [egs_pkg::WIDTH-1:0] res
);

  logic                        busy;
  logic [egs_pkg::CNT_W-1:0]   cnt;
  logic [egs_pkg::WIDTH-1:0]   acc;
  logic [egs_pkg::WIDTH-1:0]   areg;
  logic [egs_pkg::WIDTH-1:0]   mreg;
  logic [egs_pkg::WIDTH-1:0]   bsh;
  logic [egs_pkg::WIDTH:0]     dbl;
  logic [egs_pkg::WIDTH:0]     dred;
  logic [egs_pkg::WIDTH:0]     sum;
  logic [egs_pkg::WIDTH-1:0]   acc_next;

  always_comb begin
    dbl  = {acc, 1'b0};
    dred = (dbl >= {1'b0, mreg}) ? dbl - {1'b0, mreg} : dbl;
    sum  = dred + {1'b0, areg};
    if (bsh[egs_pkg::WIDTH-1]) begin
      acc_next = (sum >= {1'b0, mreg}) ? egs_pkg::WIDTH'(sum - {1'b0, mreg})
                                       : sum[egs_pkg::WIDTH-1:0];
    end else begin
      acc_next = dred[egs_pkg::WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        areg <= req.a;
        mreg <= req.m;
        bsh  <= req.b;
      end else if (busy) begin
        acc <= acc_next;
        bsh <= {bsh[egs_pkg::WIDTH-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == egs_pkg::CNT_W'(egs_pkg::WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = acc;

endmodule

// File: design/egs_divider.sv
// ----------------------------------------------------------------------------
// egs_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module egs_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  egs_pkg::div_req_t         req,
  output logic                      done,
  output logic [egs_pkg::WIDTH-1:0] quo,
  output logic [egs_pkg::WIDTH-1:0] rem
);

  logic                      busy;
  logic [egs_pkg::CNT_W-1:0] cnt;
  logic [egs_pkg::WIDTH-1:0] dreg;
  logic [egs_pkg::WIDTH-1:0] qsh;
  logic [egs_pkg::WIDTH:0]   trial;
  logic                      ge;

  always_comb begin
    trial = {rem, qsh[egs_pkg::WIDTH-1]};
    ge    = (trial >= {1'b0, dreg});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        qsh  <= req.num;
        dreg <= req.den;
      end else if (busy) begin
        rem <= ge ? egs_pkg::WIDTH'(trial - {1'b0, dreg}) : trial[egs_pkg::WIDTH-1:0];
        qsh <= {qsh[egs_pkg::WIDTH-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == egs_pkg::CNT_W'(egs_pkg::WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = qsh;

endmodule

// File: design/elgamal_signature_engine_top.sv
// ----------------------------------------------------------------------------
// elgamal_signature_engine_top
// ElGamal key generation, signing and verification over a configured prime.
//
// Channel   Direction  Handshake                 Payload
// item in   in         start & !busy             op, message, nonce, check_r,
//                                                check_s, check_key
// result    out        done (one-cycle strobe)   sig_r, sig_s, public_key,
//                                                valid_res, status
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// One item at a time. Every product and every division runs on a bit-serial
// unit; an exponentiation takes one division plus up to 2*WIDTH products.
// Synchronous reset returns the registers to p=19, g=10, x=16 and idles.
// The result cannot be stalled; it holds until the next item is accepted.
// ----------------------------------------------------------------------------
`include "elgamal_signature_engine_top_assert.svh"

module elgamal_signature_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [31:0] message,
  input  logic [31:0] nonce,
  input  logic [31:0] check_r,
  input  logic [31:0] check_s,
  input  logic [31:0] check_key,
  output logic        done,
  output logic [31:0] sig_r,
  output logic [31:0] sig_s,
  output logic [31:0] public_key,
  output logic        valid_res,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DISPATCH = 11'b00000000010,
    S_WAIT     = 11'b00000000100,
    S_PLOAD    = 11'b00000001000,
    S_PLOOP    = 11'b00000010000,
    S_PACC     = 11'b00000100000,
    S_PSQ      = 11'b00001000000,
    S_EUCL     = 11'b00010000000,
    S_EQ       = 11'b00100000000,
    S_EM       = 11'b01000000000,
    S_SPARE    = 11'b10000000000
  } state_t;

  state_t state;
  state_t ret;
  logic [2:0] ph;

  logic [egs_pkg::WIDTH-1:0] prime, gen, key;
  logic [1:0]                op_l;
  logic [egs_pkg::WIDTH-1:0] m_l, k_l, cr_l, cs_l, cy_l;
  logic [egs_pkg::WIDTH-1:0] acc, base, e, rv, tmp, ea, eb, c0, c1;

  egs_pkg::mul_req_t         mreq;
  egs_pkg::div_req_t         dreq;
  logic                      mul_done, div_done;
  logic [egs_pkg::WIDTH-1:0] mul_res, div_quo, div_rem;

  logic [egs_pkg::WIDTH-1:0] n;
  logic [egs_pkg::WIDTH-1:0] r_mod_n;
  logic [egs_pkg::WIDTH-1:0] c_next;
  logic [egs_pkg::WIDTH-1:0] diff;

  function automatic logic [egs_pkg::WIDTH-1:0] sub_mod(
    input logic [egs_pkg::WIDTH-1:0] a,
    input logic [egs_pkg::WIDTH-1:0] b,
    input logic [egs_pkg::WIDTH-1:0] md
  );
    return (a >= b) ? a - b : a + (md - b);
  endfunction

  assign n       = prime - 1'b1;
  assign r_mod_n = (rv == n) ? '0 : rv;
  assign c_next  = sub_mod(c0, mul_res, n);
  assign diff    = sub_mod(tmp, mul_res, n);
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  egs_modmul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mul_done),
    .res  (mul_res)
  );

  egs_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= egs_pkg::PRIME_RST;
      gen   <= egs_pkg::GEN_RST;
      key   <= egs_pkg::KEY_RST;
    end else if (cfg_valid && cfg_ready) begin
      priority if (cfg_index == egs_pkg::REG_PRIME) begin
        prime <= cfg_data;
      end else if (cfg_index == egs_pkg::REG_GEN) begin
        gen <= cfg_data;
      end else if (cfg_index == egs_pkg::REG_KEY) begin
        key <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      ph         <= '0;
      done       <= 1'b0;
      mreq.start <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      done       <= 1'b0;
      mreq.start <= 1'b0;
      dreq.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_l       <= op;
            m_l        <= message;
            k_l        <= nonce;
            cr_l       <= check_r;
            cs_l       <= check_s;
            cy_l       <= check_key;
            sig_r      <= '0;
            sig_s      <= '0;
            public_key <= '0;
            valid_res  <= 1'b0;
            status     <= 1'b0;
            ph         <= '0;
            state      <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (ph == 3'd0) begin
            if (prime < egs_pkg::WIDTH'(2) || op_l == egs_pkg::OP_NONE) begin
              status <= (op_l == egs_pkg::OP_SIGN);
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              // open the first exponentiation: reduce the base first
              dreq.start <= 1'b1;
              dreq.num   <= gen;
              dreq.den   <= prime;
              acc        <= egs_pkg::WIDTH'(1);
              ret        <= S_PLOAD;
              state      <= S_WAIT;
              if (op_l == egs_pkg::OP_KEYGEN) begin
                e <= key;
              end else if (op_l == egs_pkg::OP_SIGN) begin
                e <= k_l;
              end else begin
                e <= m_l;
              end
            end
          end else if (op_l == egs_pkg::OP_KEYGEN) begin
            public_key <= acc;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if (op_l == egs_pkg::OP_SIGN) begin
            unique case (ph)
              3'd1: begin
                sig_r      <= acc;
                rv         <= acc;
                dreq.start <= 1'b1;
                dreq.num   <= k_l;
                dreq.den   <= n;
                ph         <= 3'd2;
                ret        <= S_DISPATCH;
                state      <= S_WAIT;
              end
              3'd2: begin
                ea    <= n;
                eb    <= div_rem;
                c0    <= '0;
                c1    <= (n == egs_pkg::WIDTH'(1)) ? '0 : egs_pkg::WIDTH'(1);
                state <= S_EUCL;
              end
              3'd3: begin
                dreq.start <= 1'b1;
                dreq.num   <= m_l;
                dreq.den   <= n;
                ph         <= 3'd4;
                ret        <= S_DISPATCH;
                state      <= S_WAIT;
              end
              3'd4: begin
                tmp        <= div_rem;
                mreq.start <= 1'b1;
                mreq.a     <= r_mod_n;
                mreq.b     <= key;
                mreq.m     <= n;
                ph         <= 3'd5;
                ret        <= S_DISPATCH;
                state      <= S_WAIT;
              end
              3'd5: begin
                // c0 holds the inverse of k
                mreq.start <= 1'b1;
                mreq.a     <= c0;
                mreq.b     <= diff;
                mreq.m     <= n;
                ph         <= 3'd6;
                ret        <= S_DISPATCH;
                state      <= S_WAIT;
              end
              default: begin
                sig_s <= mul_res;
                done  <= 1'b1;
                state <= S_IDLE;
              end
            endcase
          end else begin
            unique case (ph)
              3'd1: begin
                tmp        <= acc;
                dreq.start <= 1'b1;
                dreq.num   <= cy_l;
                dreq.den   <= prime;
                e          <= cr_l;
                acc        <= egs_pkg::WIDTH'(1);
                ret        <= S_PLOAD;
                state      <= S_WAIT;
              end
              3'd2: begin
                rv         <= acc;
                dreq.start <= 1'b1;
                dreq.num   <= cr_l;
                dreq.den   <= prime;
                e          <= cs_l;
                acc        <= egs_pkg::WIDTH'(1);
                ret        <= S_PLOAD;
                state      <= S_WAIT;
              end
              3'd3: begin
                mreq.start <= 1'b1;
                mreq.a     <= rv;
                mreq.b     <= acc;
                mreq.m     <= prime;
                ph         <= 3'd4;
                ret        <= S_DISPATCH;
                state      <= S_WAIT;
              end
              default: begin
                valid_res <= (tmp == mul_res);
                done      <= 1'b1;
                state     <= S_IDLE;
              end
            endcase
          end
        end
        S_WAIT: begin
          if (mul_done || div_done) begin
            state <= ret;
          end
        end
        S_PLOAD: begin
          base  <= div_rem;
          state <= S_PLOOP;
        end
        S_PLOOP: begin
          if (e == '0) begin
            ph    <= ph + 1'b1;
            state <= S_DISPATCH;
          end else if (e[0]) begin
            mreq.start <= 1'b1;
            mreq.a     <= acc;
            mreq.b     <= base;
            mreq.m     <= prime;
            ret        <= S_PACC;
            state      <= S_WAIT;
          end else begin
            mreq.start <= 1'b1;
            mreq.a     <= base;
            mreq.b     <= base;
            mreq.m     <= prime;
            ret        <= S_PSQ;
            state      <= S_WAIT;
          end
        end
        S_PACC: begin
          acc        <= mul_res;
          mreq.start <= 1'b1;
          mreq.a     <= base;
          mreq.b     <= base;
          mreq.m     <= prime;
          ret        <= S_PSQ;
          state      <= S_WAIT;
        end
        S_PSQ: begin
          base  <= mul_res;
          e     <= e >> 1;
          state <= S_PLOOP;
        end
        S_EUCL: begin
          if (eb == '0) begin
            if (ea != egs_pkg::WIDTH'(1)) begin
              status <= 1'b1;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              ph    <= 3'd3;
              state <= S_DISPATCH;
            end
          end else begin
            dreq.start <= 1'b1;
            dreq.num   <= ea;
            dreq.den   <= eb;
            ret        <= S_EQ;
            state      <= S_WAIT;
          end
        end
        S_EQ: begin
          ea         <= eb;
          eb         <= div_rem;
          mreq.start <= 1'b1;
          mreq.a     <= c1;
          mreq.b     <= div_quo;
          mreq.m     <= n;
          ret        <= S_EM;
          state      <= S_WAIT;
        end
        S_EM: begin
          c0    <= c1;
          c1    <= c_next;
          state <= S_EUCL;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `EGS_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `EGS_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "item accepted but not busy")
  `EGS_ASSERT_NOW(a_err_s_zero, clk, rst, done && status, sig_s == '0, "error with nonzero s")
  `EGS_ASSERT_NOW(a_one_unit, clk, rst, mul_done || div_done, state == S_WAIT,
                  "unit finished outside wait")

endmodule
